[design/linear_probe_handle_table_unit_defines.svh]
// assertion macros shared by the handle table rtl
`ifndef LINEAR_PROBE_HANDLE_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HANDLE_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while in reset
`define LPHT_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lpht assertion failed");
// next-cycle implication
`define LPHT_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMP(name, pre, post)
`define LPHT_ASSERT_NXT(name, pre, post)
`endif
`endif

[design/lpht_pkg.sv]
// types and constants of the linear probing handle table
package lpht_pkg;

  localparam int ID_W     = 32;
  localparam int HANDLE_W = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     key_id;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic [HANDLE_W-1:0] result_handle;
  } out_item_t;

  typedef struct packed {
    logic                live;
    logic                used;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_RESP
  } state_t;

endpackage

[design/lpht_hash.sv]
// home slot unit: id modulo table depth
module lpht_hash #(
  parameter int DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lpht_pkg::ID_W-1:0] value,
  output logic                      done,
  output logic [$clog2(DEPTH)-1:0]  rem
);

  localparam int IDX_W = $clog2(DEPTH);

  generate
    if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
      // power of two depth: the low bits are the remainder
      logic             done_r;
      logic [IDX_W-1:0] rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= value[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_recip
      // quotient by reciprocal multiplication on start, exact over the whole id range,
      // then the remainder from the low bits in the next cycle
      localparam int SHIFT = lpht_pkg::ID_W + IDX_W;
      localparam int MUL_W = lpht_pkg::ID_W + 1;
      localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
      localparam logic [MUL_W-1:0] RECIP = RECIP_WIDE[MUL_W-1:0];
      localparam logic [IDX_W-1:0] DEP   = IDX_W'(DEPTH);

      logic                            busy_r;
      logic                            done_r;
      logic [IDX_W-1:0]                val_r;
      logic [IDX_W-1:0]                quo_r;
      logic [IDX_W-1:0]                rem_r;
      logic [lpht_pkg::ID_W+MUL_W-1:0] prod;
      logic [2*IDX_W-1:0]              back;

      assign prod = value * RECIP;
      // remainder is below the depth, so the low bits of id - quotient * depth suffice
      assign back = quo_r * DEP;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          busy_r <= start;
          done_r <= busy_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          val_r <= value[IDX_W-1:0];
          quo_r <= prod[SHIFT +: IDX_W];
        end
        if (busy_r) begin
          rem_r <= val_r - back[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

[design/lpht_slot_mem.sv]
// slot store: one write port, one registered read port
module lpht_slot_mem #(
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  lpht_pkg::slot_t          wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output lpht_pkg::slot_t          rd_data
);

  lpht_pkg::slot_t mem [DEPTH];
  lpht_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/linear_probe_handle_table_unit.sv]
// handle table with linear probing and tombstones: sequencer and top level
// Handle table of TABLE_DEPTH slots, probed linearly from the home slot id mod
// TABLE_DEPTH. After reset a clearing pass marks every slot empty; in_ready stays
// low until it ends. One item is worked on at a time and the slot memory is read
// one slot a cycle; an insert, search or remove passes through the hash and probe
// states, where the home slot is the low id bits when TABLE_DEPTH is a power of
// two and comes from a reciprocal multiplication otherwise. An insert into a full
// table and an unknown action go straight to the response. A finished result
// sits in the output register while the next item is taken in.
module linear_probe_handle_table_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpht_pkg::out_item_t out_data
);

`include "linear_probe_handle_table_unit_defines.svh"

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0]  IDX_ONE  = IDX_W'(1);
  localparam logic [LIVE_W-1:0] FULL_CNT = LIVE_W'(TABLE_DEPTH);
  localparam logic [LIVE_W-1:0] LIVE_ONE = LIVE_W'(1);
  localparam logic [lpht_pkg::ID_W-1:0] ID_ONE = lpht_pkg::ID_W'(1);

  lpht_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]              clr_r;
  logic [lpht_pkg::ACTION_W-1:0] act_r;
  logic [lpht_pkg::HANDLE_W-1:0] handle_r;
  logic [lpht_pkg::ID_W-1:0]     key_r;
  logic [lpht_pkg::ID_W-1:0]     next_id_r;
  logic [LIVE_W-1:0]             live_cnt_r;
  logic [IDX_W-1:0]              pos_r;
  logic [IDX_W-1:0]              chk_pos_r;
  logic [IDX_W-1:0]              cnt_r;
  logic                          dv_r;
  lpht_pkg::out_item_t           res_r;
  logic                          out_valid_r;
  lpht_pkg::out_item_t           out_data_r;

  logic                      accept;
  logic                      is_ins;
  logic                      in_is_ins;
  logic                      in_is_lookup;
  logic                      table_full;
  logic                      probe_hit;
  logic                      probe_miss;
  logic                      out_load;
  logic                      hash_start;
  logic [lpht_pkg::ID_W-1:0] hash_key;
  logic                      hash_done;
  logic [IDX_W-1:0]          hash_rem;
  logic                      mem_wr_en;
  logic [IDX_W-1:0]          mem_wr_addr;
  lpht_pkg::slot_t           mem_wr_data;
  lpht_pkg::slot_t           rd_slot;

  assign in_ready     = (state_r == lpht_pkg::ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign in_is_ins    = (in_data.action == lpht_pkg::ACT_INSERT);
  assign in_is_lookup = (in_data.action == lpht_pkg::ACT_SEARCH) ||
                        (in_data.action == lpht_pkg::ACT_REMOVE);
  assign table_full   = (live_cnt_r == FULL_CNT);
  assign is_ins       = (act_r == lpht_pkg::ACT_INSERT);
  assign hash_key     = in_is_ins ? next_id_r : in_data.key_id;
  assign out_load     = !out_valid_r || out_ready;

  // insert stops at the first slot not live; lookups at a live match, and miss at an unused slot or after a full lap
  assign probe_hit  = dv_r && (is_ins ? !rd_slot.live
                                      : (rd_slot.live && (rd_slot.id == key_r)));
  assign probe_miss = dv_r && !is_ins && !probe_hit &&
                      (!rd_slot.used || (cnt_r == LAST_IDX));

  lpht_hash #(
    .DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .value (hash_key),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  lpht_slot_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (pos_r),
    .rd_data (rd_slot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        if (clr_r == LAST_IDX) state_nxt = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        if (accept) state_nxt = hash_start ? lpht_pkg::ST_HASH : lpht_pkg::ST_RESP;
      end
      lpht_pkg::ST_HASH: begin
        if (hash_done) state_nxt = lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_PROBE: begin
        if (probe_hit || probe_miss) state_nxt = lpht_pkg::ST_RESP;
      end
      lpht_pkg::ST_RESP: begin
        if (out_load) state_nxt = lpht_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lpht_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    hash_start  = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = chk_pos_r;
    mem_wr_data = '0;
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
      end
      lpht_pkg::ST_IDLE: begin
        hash_start = accept && ((in_is_ins && !table_full) || in_is_lookup);
      end
      lpht_pkg::ST_PROBE: begin
        if (probe_hit && is_ins) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = '{live: 1'b1, used: 1'b1, id: key_r, handle: handle_r};
        end else if (probe_hit && (act_r == lpht_pkg::ACT_REMOVE)) begin
          // tombstone: not live, still used
          mem_wr_en   = 1'b1;
          mem_wr_data = '{live: 1'b0, used: 1'b1, id: '0, handle: '0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::ST_CLEAR;
      clr_r       <= '0;
      next_id_r   <= '0;
      live_cnt_r  <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lpht_pkg::ST_CLEAR) clr_r <= clr_r + IDX_ONE;
      if (state_r == lpht_pkg::ST_HASH) dv_r <= 1'b0;
      if (state_r == lpht_pkg::ST_PROBE) begin
        dv_r <= !(probe_hit || probe_miss);
        if (probe_hit && is_ins) begin
          next_id_r  <= next_id_r + ID_ONE;
          live_cnt_r <= live_cnt_r + LIVE_ONE;
        end else if (probe_hit && (act_r == lpht_pkg::ACT_REMOVE)) begin
          live_cnt_r <= live_cnt_r - LIVE_ONE;
        end
      end
      if ((state_r == lpht_pkg::ST_RESP) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lpht_pkg::ST_IDLE: begin
        if (accept) begin
          act_r    <= in_data.action;
          handle_r <= in_data.handle;
          key_r    <= hash_key;
          if (in_is_ins) begin
            res_r <= '{status: lpht_pkg::STAT_FULL, result_id: '0, result_handle: '0};
          end else begin
            res_r <= '{status: lpht_pkg::STAT_NOT_FOUND, result_id: in_data.key_id,
                       result_handle: '0};
          end
        end
      end
      lpht_pkg::ST_HASH: begin
        pos_r <= hash_rem;
        cnt_r <= '0;
      end
      lpht_pkg::ST_PROBE: begin
        pos_r     <= (pos_r == LAST_IDX) ? '0 : (pos_r + IDX_ONE);
        chk_pos_r <= pos_r;
        if (dv_r) cnt_r <= cnt_r + IDX_ONE;
        if (probe_hit) begin
          res_r <= '{status: lpht_pkg::STAT_OK, result_id: key_r,
                     result_handle: is_ins ? '0 : rd_slot.handle};
        end else if (probe_miss) begin
          res_r <= '{status: lpht_pkg::STAT_NOT_FOUND, result_id: key_r,
                     result_handle: '0};
        end
      end
      lpht_pkg::ST_RESP: begin
        if (out_load) out_data_r <= res_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LPHT_ASSERT_NXT(a_full_refused, accept && in_is_ins && table_full,
    (state_r == lpht_pkg::ST_RESP) && (res_r.status == lpht_pkg::STAT_FULL))
  `LPHT_ASSERT_NXT(a_insert_counts, (state_r == lpht_pkg::ST_PROBE) && probe_hit && is_ins,
    (live_cnt_r == $past(live_cnt_r) + LIVE_ONE) && (next_id_r == $past(next_id_r) + ID_ONE))
  `LPHT_ASSERT_IMP(a_write_source, mem_wr_en,
    (state_r == lpht_pkg::ST_CLEAR) || ((state_r == lpht_pkg::ST_PROBE) && probe_hit))
  `LPHT_ASSERT_IMP(a_live_bound, (state_r == lpht_pkg::ST_PROBE) && is_ins,
    live_cnt_r != FULL_CNT)

endmodule

[bench/linear_probe_handle_table_unit_test.sv]
// self-checking bench for the linear probing handle table: directed rows, then random traffic
module linear_probe_handle_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 128;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS = 100;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 200;
  localparam logic [lpht_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [lpht_pkg::ID_W-1:0] ALL_ONES = '1;

  typedef struct {
    lpht_pkg::in_item_t  stim;
    bit                  fixed;
    lpht_pkg::out_item_t reply;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lpht_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lpht_pkg::out_item_t out_data;

  // own copy of the table
  logic                          slot_live [DEPTH];
  logic                          slot_used [DEPTH];
  logic [lpht_pkg::ID_W-1:0]     slot_id [DEPTH];
  logic [lpht_pkg::HANDLE_W-1:0] slot_handle [DEPTH];
  logic [lpht_pkg::ID_W-1:0]     issue_id;
  int                            live_total;

  lpht_pkg::out_item_t       replies_due[$];
  logic [lpht_pkg::ID_W-1:0] gone_ids[$];
  row_t                      rows[$];
  int                        fails;
  bit                        calm;
  bit                        long_hold_req;
  int                        n_items, n_insert, n_full, n_hit, n_miss, n_unknown;

  linear_probe_handle_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

  // returns the slot holding key, or -1 once the probe run ends
  function automatic int locate(logic [lpht_pkg::ID_W-1:0] key);
    int pos;
    pos = int'(key % DEPTH);
    for (int n = 0; n < DEPTH; n++) begin
      if (slot_live[pos] && slot_id[pos] == key) return pos;
      if (!slot_used[pos]) return -1;
      pos = (pos + 1) % DEPTH;
    end
    return -1;
  endfunction

  function automatic lpht_pkg::out_item_t apply_to_table(lpht_pkg::in_item_t it);
    lpht_pkg::out_item_t r;
    int pos;
    r.status = lpht_pkg::STAT_NOT_FOUND;
    r.result_id = it.key_id;
    r.result_handle = '0;
    n_items++;
    case (it.action)
      lpht_pkg::ACT_INSERT: begin
        n_insert++;
        r.result_id = '0;
        if (live_total >= DEPTH) begin
          r.status = lpht_pkg::STAT_FULL;
          n_full++;
        end else begin
          pos = int'(issue_id % DEPTH);
          while (slot_live[pos]) pos = (pos + 1) % DEPTH;
          slot_live[pos] = 1'b1;
          slot_used[pos] = 1'b1;
          slot_id[pos] = issue_id;
          slot_handle[pos] = it.handle;
          live_total++;
          r.status = lpht_pkg::STAT_OK;
          r.result_id = issue_id;
          issue_id = issue_id + 1'b1;
        end
      end
      lpht_pkg::ACT_SEARCH, lpht_pkg::ACT_REMOVE: begin
        pos = locate(it.key_id);
        if (pos >= 0) begin
          n_hit++;
          r.status = lpht_pkg::STAT_OK;
          r.result_handle = slot_handle[pos];
          if (it.action == lpht_pkg::ACT_REMOVE) begin
            // leaves a tombstone: used stays set
            slot_live[pos] = 1'b0;
            live_total--;
            gone_ids.push_back(it.key_id);
            if (gone_ids.size() > 16) void'(gone_ids.pop_front());
          end
        end else begin
          n_miss++;
        end
      end
      default: n_unknown++;
    endcase
    return r;
  endfunction

  function automatic logic [lpht_pkg::ID_W-1:0] any_live_id();
    int k;
    if (live_total == 0) return issue_id;
    k = $urandom_range(0, live_total - 1);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_live[i]) begin
        if (k == 0) return slot_id[i];
        k--;
      end
    end
    return issue_id;
  endfunction

  function automatic logic [lpht_pkg::HANDLE_W-1:0] any_handle();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [lpht_pkg::ID_W-1:0] stale_id();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return gone_ids.size() ? gone_ids[$urandom_range(0, gone_ids.size() - 1)] : $urandom;
      2: return issue_id;
      default: return any_live_id() + DEPTH * $urandom_range(1, 4);
    endcase
  endfunction

  task automatic add_row(logic [lpht_pkg::ACTION_W-1:0] act,
                         logic [lpht_pkg::HANDLE_W-1:0] h,
                         logic [lpht_pkg::ID_W-1:0] key);
    row_t row;
    row.stim = '{action: act, handle: h, key_id: key};
    row.fixed = 1'b0;
    row.reply = '0;
    rows.push_back(row);
  endtask

  task automatic add_fixed(logic [lpht_pkg::ACTION_W-1:0] act,
                           logic [lpht_pkg::HANDLE_W-1:0] h,
                           logic [lpht_pkg::ID_W-1:0] key,
                           logic [lpht_pkg::STATUS_W-1:0] st,
                           logic [lpht_pkg::ID_W-1:0] rid,
                           logic [lpht_pkg::HANDLE_W-1:0] rh);
    row_t row;
    row.stim = '{action: act, handle: h, key_id: key};
    row.fixed = 1'b1;
    row.reply = '{status: st, result_id: rid, result_handle: rh};
    rows.push_back(row);
  endtask

  // called just after an acceptance edge or at the start; returns at the next acceptance
  task automatic offer(lpht_pkg::in_item_t it, bit fixed, lpht_pkg::out_item_t reply);
    lpht_pkg::out_item_t want;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = apply_to_table(it);
    replies_due.push_back(fixed ? reply : want);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(1, 5) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lpht_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("result with no item waiting: status %0d id %h handle %h",
               out_data.status, out_data.result_id, out_data.result_handle);
        fails++;
      end else begin
        want = replies_due.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fails++;
        end
        if (out_data.result_id !== want.result_id) begin
          $error("result_id: expected %h, got %h", want.result_id, out_data.result_id);
          fails++;
        end
        if (out_data.result_handle !== want.result_handle) begin
          $error("result_handle: expected %h, got %h",
                 want.result_handle, out_data.result_handle);
          fails++;
        end
      end
    end
  end

  initial begin
    lpht_pkg::in_item_t it;
    bit filling;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    fails = 0;
    n_items = 0;
    n_insert = 0;
    n_full = 0;
    n_hit = 0;
    n_miss = 0;
    n_unknown = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_live[i] = 1'b0;
      slot_used[i] = 1'b0;
      slot_id[i] = '0;
      slot_handle[i] = '0;
    end
    issue_id = '0;
    live_total = 0;

    // empty table, zero and all-ones handles, tombstones, unknown action
    add_fixed(lpht_pkg::ACT_SEARCH, '0, '0, lpht_pkg::STAT_NOT_FOUND, '0, '0);
    add_fixed(lpht_pkg::ACT_REMOVE, '1, ALL_ONES, lpht_pkg::STAT_NOT_FOUND, ALL_ONES, '0);
    add_fixed(ACT_UNKNOWN, '1, 32'hA5A5_A5A5, lpht_pkg::STAT_NOT_FOUND, 32'hA5A5_A5A5, '0);
    add_fixed(lpht_pkg::ACT_INSERT, '0, ALL_ONES, lpht_pkg::STAT_OK, 32'd0, '0);
    add_fixed(lpht_pkg::ACT_INSERT, '1, '0, lpht_pkg::STAT_OK, 32'd1, '0);
    add_fixed(lpht_pkg::ACT_SEARCH, '0, 32'd0, lpht_pkg::STAT_OK, 32'd0, '0);
    add_fixed(lpht_pkg::ACT_SEARCH, '0, 32'd1, lpht_pkg::STAT_OK, 32'd1, '1);
    add_row(lpht_pkg::ACT_SEARCH, '0, 32'd128);
    add_fixed(lpht_pkg::ACT_REMOVE, '0, 32'd0, lpht_pkg::STAT_OK, 32'd0, '0);
    add_row(lpht_pkg::ACT_SEARCH, 32'h5A5A_5A5A, 32'd128);
    add_fixed(lpht_pkg::ACT_SEARCH, '0, 32'd0, lpht_pkg::STAT_NOT_FOUND, 32'd0, '0);
    add_row(lpht_pkg::ACT_INSERT, 32'h1234_5678, 32'd7);
    add_row(lpht_pkg::ACT_INSERT, 32'h0F0F_0F0F, '0);
    add_fixed(lpht_pkg::ACT_REMOVE, '0, 32'd1, lpht_pkg::STAT_OK, 32'd1, '1);
    add_fixed(lpht_pkg::ACT_REMOVE, '0, 32'd1, lpht_pkg::STAT_NOT_FOUND, 32'd1, '0);
    add_row(lpht_pkg::ACT_SEARCH, '0, 32'h8000_0002);
    add_row(lpht_pkg::ACT_SEARCH, '1, 32'd2);
    add_row(lpht_pkg::ACT_REMOVE, '0, 32'd3);
    add_row(lpht_pkg::ACT_SEARCH, '0, ALL_ONES);
    add_row(ACT_UNKNOWN, '0, '0);

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) offer(rows[i].stim, rows[i].fixed, rows[i].reply);

    // random part: alternate filling to full and draining through tombstones
    filling = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
      if (k == 300) long_hold_req = 1'b1;
      if (filling && live_total == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && live_total <= 8) filling = 1'b1;
      r = $urandom_range(0, 99);
      it.handle = any_handle();
      it.key_id = $urandom;
      if (r < (filling ? 75 : 8)) begin
        it.action = lpht_pkg::ACT_INSERT;
      end else if (r < (filling ? 85 : 20)) begin
        it.action = lpht_pkg::ACT_SEARCH;
        it.key_id = any_live_id();
      end else if (r < (filling ? 88 : 80)) begin
        it.action = lpht_pkg::ACT_REMOVE;
        it.key_id = any_live_id();
      end else if (r < (filling ? 94 : 90)) begin
        it.action = lpht_pkg::ACT_SEARCH;
        it.key_id = stale_id();
      end else if (r < (filling ? 97 : 96)) begin
        it.action = lpht_pkg::ACT_REMOVE;
        it.key_id = stale_id();
      end else begin
        it.action = ACT_UNKNOWN;
      end
      offer(it, 1'b0, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d inserts (%0d refused on a full table), %0d unknown actions",
             n_items, n_insert, n_full, n_unknown);
    $display("lookups and removals: %0d found, %0d not found", n_hit, n_miss);
    if (fails == 0 && replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
